FILE: rtl/core/ssr_pkg.sv
// Shared types and constants for the streaming substring replace block.
package ssr_pkg;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int LEN_W       = 4;
    localparam int CFG_INDEX_W = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUBSTITUTE_BYTES  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SUBSTITUTE_LENGTH = 4'd3;

    // One input transaction
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              has_byte;
        logic              end_of_text;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              text_done;
    } result_t;

    // Configuration as seen by the engine
    typedef struct packed {
        logic [WORD_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]  pattern_length;
        logic [WORD_W-1:0] substitute_bytes;
        logic [LEN_W-1:0]  substitute_length;
    } cfg_t;

endpackage

FILE: rtl/core/stream_substring_replace.sv
// Top level of the streaming substring find-and-replace block.
//
// Usage: text enters one byte per transaction on the input queue (push/full);
// each transaction carries text_byte, has_byte and end_of_text. Rewritten
// bytes leave through the result queue (empty/pop), oldest first, each with
// last_of_run on the final byte caused by its input and text_done on the
// final byte of an end-of-text input. Transactions that cause no byte give
// no result at all. Configuration (pattern, substitute and their lengths)
// is written on cfg_valid/cfg_ready, always ready, between texts.
// Sequence: the engine takes a byte item, loads it into the pending buffer,
// scans the buffer against the pattern, emitting substitute or dropped bytes,
// and finishes; an item that also ends the text flushes the held bytes first,
// and an end-only item only flushes and finishes. A byte passed straight
// through goes via the input queue, the pending buffer, the staging register
// and the result queue. The input is buffered two deep, so a new item is
// accepted while the engine works. The rate is set by the engine sequencer,
// which handles one item at a time and emits at most one byte per cycle.
// Reset clears the pending count, both queues and all configuration.
// When the receiver stalls, the output queue fills, the engine holds and the
// input queue then raises full; nothing is dropped.
module stream_substring_replace #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_SUBST   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input queue
    input  logic                              push,
    output logic                              full,
    input  logic [ssr_pkg::BYTE_W-1:0]        text_byte,
    input  logic                              has_byte,
    input  logic                              end_of_text,
    // result queue
    output logic                              empty,
    input  logic                              pop,
    output logic [ssr_pkg::BYTE_W-1:0]        out_byte,
    output logic                              last_of_run,
    output logic                              text_done,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ssr_pkg::WORD_W-1:0]        cfg_data
);

    localparam int RES_W = $bits(ssr_pkg::result_t);

    ssr_pkg::cfg_t    cfg_reg;
    ssr_pkg::cfg_t    cfg_next;
    ssr_pkg::item_t   item_in;
    ssr_pkg::item_t   item_q;
    logic             item_valid;
    logic             item_ready;
    logic             res_push;
    ssr_pkg::result_t res_data;
    logic             res_full;
    logic [RES_W-1:0] res_rd_data;
    ssr_pkg::result_t res_out;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ssr_pkg::REG_PATTERN_BYTES:
                begin
                    cfg_next.pattern_bytes = cfg_data;
                end
                ssr_pkg::REG_PATTERN_LENGTH:
                begin
                    cfg_next.pattern_length = cfg_data[ssr_pkg::LEN_W-1:0];
                end
                ssr_pkg::REG_SUBSTITUTE_BYTES:
                begin
                    cfg_next.substitute_bytes = cfg_data;
                end
                ssr_pkg::REG_SUBSTITUTE_LENGTH:
                begin
                    cfg_next.substitute_length = cfg_data[ssr_pkg::LEN_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Gather the input fields into one transaction
    always_comb
    begin
        item_in.text_byte   = text_byte;
        item_in.has_byte    = has_byte;
        item_in.end_of_text = end_of_text;
    end

    ssr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_out   (item_q)
    );

    ssr_engine #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_SUBST   (MAX_SUBST)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_in    (item_q),
        .res_push   (res_push),
        .res_data   (res_data),
        .res_full   (res_full)
    );

    ssr_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    // Present the oldest result
    assign res_out     = ssr_pkg::result_t'(res_rd_data);
    assign out_byte    = res_out.out_byte;
    assign last_of_run = res_out.last_of_run;
    assign text_done   = res_out.text_done;

endmodule

FILE: rtl/core/ssr_fifo.sv
// Two-entry first-word-fall-through queue used on both sides of the engine.
module ssr_fifo #(
    parameter int WIDTH = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the written entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/ssr_front.sv
// Front end: accepts input transactions, drops empty ones and queues the rest.
module ssr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  ssr_pkg::item_t item_in,
    output logic           item_valid,
    input  logic           item_ready,
    output ssr_pkg::item_t item_out
);

    localparam int ITEM_W = $bits(ssr_pkg::item_t);

    logic              keep;
    logic              q_empty;
    logic [ITEM_W-1:0] q_rd_data;

    // Classify: an item with neither a byte nor an end produces nothing
    assign keep = item_in.has_byte || item_in.end_of_text;

    ssr_fifo #(
        .WIDTH (ITEM_W)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (item_in),
        .full    (full),
        .rd_en   (item_ready),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign item_valid = !q_empty;
    assign item_out   = ssr_pkg::item_t'(q_rd_data);

endmodule

FILE: rtl/core/ssr_engine.sv
// Back end: pending buffer, match/drop sequencer and result staging.
module ssr_engine #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_SUBST   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ssr_pkg::cfg_t    cfg,
    input  logic             item_valid,
    output logic             item_ready,
    input  ssr_pkg::item_t   item_in,
    output logic             res_push,
    output ssr_pkg::result_t res_data,
    input  logic             res_full
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SL_W  = (MAX_SUBST > 0) ? $clog2(MAX_SUBST + 1) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SETTLE = 3'd2;
    localparam logic [2:0] S_SUB    = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [ssr_pkg::BYTE_W-1:0]  buf_reg [MAX_PATTERN];
    logic [ssr_pkg::BYTE_W-1:0]  buf_next [MAX_PATTERN];
    ssr_pkg::item_t              item_reg;
    ssr_pkg::item_t              item_next;
    logic [SL_W-1:0]             sub_idx_reg;
    logic [SL_W-1:0]             sub_idx_next;
    logic [ssr_pkg::BYTE_W-1:0]  stage_reg;
    logic [ssr_pkg::BYTE_W-1:0]  stage_next;
    logic                        stage_valid_reg;
    logic                        stage_valid_next;

    logic [CNT_W-1:0]            plen;
    logic [SL_W-1:0]             slen;
    logic [MAX_PATTERN-1:0]      mism;
    logic                        is_prefix;
    logic                        match;
    logic                        drop;
    logic                        can_emit;
    logic                        emit_en;
    logic [ssr_pkg::BYTE_W-1:0]  emit_byte;
    logic [ssr_pkg::WORD_W-1:0]  sub_shifted;
    logic [2:0]                  after_settle;
    logic                        sub_last;

    // Clamp configured lengths to the supported sizes
    assign plen = (cfg.pattern_length > ssr_pkg::LEN_W'(MAX_PATTERN))
                  ? CNT_W'(MAX_PATTERN) : cfg.pattern_length[CNT_W-1:0];
    assign slen = (cfg.substitute_length > ssr_pkg::LEN_W'(MAX_SUBST))
                  ? SL_W'(MAX_SUBST) : cfg.substitute_length[SL_W-1:0];

    // Compare held bytes against the pattern head
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            mism[i] = (CNT_W'(i) < cnt_reg) &&
                      (buf_reg[i] != cfg.pattern_bytes[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W]);
        end
    end

    assign is_prefix    = ~|mism;
    assign match        = (plen != '0) && (cnt_reg == plen) && is_prefix;
    assign drop         = (cnt_reg >= plen) || !is_prefix;
    assign can_emit     = !stage_valid_reg || !res_full;
    assign item_ready   = (state_reg == S_IDLE);
    assign sub_shifted  = cfg.substitute_bytes >> {sub_idx_reg, 3'b000};
    assign sub_last     = (sub_idx_reg == slen - SL_W'(1));
    assign after_settle = item_reg.end_of_text ? S_FLUSH : S_FIN;

    // Sequence one item: load, settle, substitute, flush, finish
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        buf_next         = buf_reg;
        item_next        = item_reg;
        sub_idx_next     = sub_idx_reg;
        stage_next       = stage_reg;
        stage_valid_next = stage_valid_reg;
        emit_en          = 1'b0;
        emit_byte        = buf_reg[0];
        res_push         = 1'b0;
        res_data         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item_in;
                    if (item_in.has_byte)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (item_in.end_of_text)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_LOAD:
            begin
                if (cnt_reg == CNT_W'(MAX_PATTERN))
                begin
                    // Full buffer: emit the oldest byte to make room
                    if (can_emit)
                    begin
                        emit_en = 1'b1;
                        for (int i = 0; i < MAX_PATTERN - 1; i++)
                        begin
                            buf_next[i] = buf_reg[i+1];
                        end
                        buf_next[MAX_PATTERN-1] = item_reg.text_byte;
                        state_next = S_SETTLE;
                    end
                end
                else
                begin
                    buf_next[cnt_reg[IDX_W-1:0]] = item_reg.text_byte;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                priority if (cnt_reg == '0)
                begin
                    state_next = after_settle;
                end
                else if (match)
                begin
                    if (slen == '0)
                    begin
                        cnt_next   = '0;
                        state_next = after_settle;
                    end
                    else
                    begin
                        sub_idx_next = '0;
                        state_next   = S_SUB;
                    end
                end
                else if (drop)
                begin
                    if (can_emit)
                    begin
                        emit_en = 1'b1;
                        for (int i = 0; i < MAX_PATTERN - 1; i++)
                        begin
                            buf_next[i] = buf_reg[i+1];
                        end
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = after_settle;
                end
            end
            S_SUB:
            begin
                if (can_emit)
                begin
                    emit_en   = 1'b1;
                    emit_byte = sub_shifted[ssr_pkg::BYTE_W-1:0];
                    if (sub_last)
                    begin
                        cnt_next   = '0;
                        state_next = after_settle;
                    end
                    else
                    begin
                        sub_idx_next = sub_idx_reg + SL_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (can_emit)
                begin
                    emit_en = 1'b1;
                    for (int i = 0; i < MAX_PATTERN - 1; i++)
                    begin
                        buf_next[i] = buf_reg[i+1];
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_FIN:
            begin
                // Release the staged byte as the last of this run
                if (!stage_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!res_full)
                begin
                    res_push             = 1'b1;
                    res_data.out_byte    = stage_reg;
                    res_data.last_of_run = 1'b1;
                    res_data.text_done   = item_reg.end_of_text;
                    stage_valid_next     = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Stage each emitted byte so the last of a run can be marked
        if (emit_en)
        begin
            if (stage_valid_reg)
            begin
                res_push             = 1'b1;
                res_data.out_byte    = stage_reg;
                res_data.last_of_run = 1'b0;
                res_data.text_done   = 1'b0;
            end
            stage_next       = emit_byte;
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            stage_valid_reg <= 1'b0;
            sub_idx_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            stage_valid_reg <= stage_valid_next;
            sub_idx_reg     <= sub_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        item_reg  <= item_next;
        stage_reg <= stage_next;
    end

    // Held byte count never exceeds the buffer depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PATTERN))
        else $error("pending count beyond buffer depth");

    // Never push a result into a full output queue
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed while output queue full");

    // Finishing a run leaves nothing staged
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !res_full) |=> (!stage_valid_reg && state_reg == S_IDLE))
        else $error("staged byte survived end of run");

    // A completed substitution empties the pending buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUB && can_emit && sub_last) |=> (cnt_reg == '0))
        else $error("pending bytes left after substitution");

    // Items are taken only while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> ($stable(item_reg) || $past(state_reg) == S_IDLE))
        else $error("item register changed mid-sequence");

endmodule

FILE: sim/stream_substring_replace_tb.sv
// Self-checking testbench for the streaming substring find-and-replace block.
module stream_substring_replace_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAT       = 8;
    localparam int MAX_SUB       = 8;
    localparam int RUN_CAP       = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 15;

    // Block ports, inputs driven to known values from time zero
    logic                            clk;
    logic                            rst_n       = 1'b0;
    logic                            push        = 1'b0;
    logic                            full;
    logic [ssr_pkg::BYTE_W-1:0]      text_byte   = '0;
    logic                            has_byte    = 1'b0;
    logic                            end_of_text = 1'b0;
    logic                            empty;
    logic                            pop         = 1'b0;
    logic [ssr_pkg::BYTE_W-1:0]      out_byte;
    logic                            last_of_run;
    logic                            text_done;
    logic                            cfg_valid   = 1'b0;
    logic                            cfg_ready;
    logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index   = ssr_pkg::REG_PATTERN_BYTES;
    logic [ssr_pkg::WORD_W-1:0]      cfg_data    = '0;

    // Rewrite predictor: configuration copy, held bytes and expected output bytes
    logic [ssr_pkg::WORD_W-1:0]      pat_word    = '0;
    logic [ssr_pkg::LEN_W-1:0]       pat_len_reg = '0;
    logic [ssr_pkg::WORD_W-1:0]      sub_word    = '0;
    logic [ssr_pkg::LEN_W-1:0]       sub_len_reg = '0;
    logic [ssr_pkg::BYTE_W-1:0]      held_bytes [MAX_PAT];
    int unsigned                     held_count  = 0;
    logic [ssr_pkg::BYTE_W-1:0]      run_bytes [$];
    ssr_pkg::result_t                expected_q [$];

    // Run bookkeeping
    bit                     gaps_on         = 1'b1;
    int                     rx_hold         = 0;
    int                     quiet_cycles    = 0;
    int unsigned            error_count     = 0;
    int unsigned            items_sent      = 0;
    int unsigned            bytes_checked   = 0;
    int unsigned            matches_seen    = 0;
    int unsigned            texts_ended     = 0;
    int unsigned            configs_written = 0;

    stream_substring_replace u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .has_byte    (has_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .text_done   (text_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned clamp_len(logic [ssr_pkg::LEN_W-1:0] len,
                                              int unsigned cap);
        return (len > cap) ? cap : int'(len);
    endfunction

    function automatic void emit_byte(logic [ssr_pkg::BYTE_W-1:0] b);
        if (run_bytes.size() < RUN_CAP)
            run_bytes.push_back(b);
    endfunction

    // Emit the oldest held byte and close up the gap
    function automatic void release_oldest();
        emit_byte(held_bytes[0]);
        for (int i = 1; i < held_count; i++)
            held_bytes[i-1] = held_bytes[i];
        held_count--;
    endfunction

    function automatic bit held_is_pattern_prefix();
        for (int i = 0; i < held_count; i++)
            if (held_bytes[i] != pat_word[i*8 +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // Work out the output bytes of one accepted transaction and queue them
    function automatic void predict_rewrite(ssr_pkg::item_t it);
        int unsigned plen;
        int unsigned slen;
        bit          settled;
        plen = clamp_len(pat_len_reg, MAX_PAT);
        slen = clamp_len(sub_len_reg, MAX_SUB);
        run_bytes.delete();
        if (it.has_byte)
        begin
            if (held_count >= MAX_PAT)
                release_oldest();
            held_bytes[held_count] = it.text_byte;
            held_count++;
            settled = 1'b0;
            // substitute a complete match, drop bytes that cannot start one
            while (held_count > 0 && !settled)
            begin
                if (plen > 0 && held_count == plen && held_is_pattern_prefix())
                begin
                    for (int i = 0; i < slen; i++)
                        emit_byte(sub_word[i*8 +: 8]);
                    held_count = 0;
                    matches_seen++;
                end
                else if (held_count >= plen || !held_is_pattern_prefix())
                    release_oldest();
                else
                    settled = 1'b1;
            end
        end
        // flush whatever is still held at the end of a text
        if (it.end_of_text)
        begin
            texts_ended++;
            while (held_count > 0)
                release_oldest();
        end
        foreach (run_bytes[k])
            expected_q.push_back(ssr_pkg::result_t'{
                out_byte:    run_bytes[k],
                last_of_run: (k == run_bytes.size() - 1),
                text_done:   (k == run_bytes.size() - 1) && it.end_of_text});
    endfunction

    task automatic report_mismatch(string what, logic [ssr_pkg::BYTE_W-1:0] got,
                                   logic [ssr_pkg::BYTE_W-1:0] want);
        $display("MISMATCH at output byte %0d: %s got %h, expected %h",
                 bytes_checked, what, got, want);
        error_count++;
    endtask

    // Compare one popped result with the oldest expectation
    task automatic check_result();
        ssr_pkg::result_t want;
        bytes_checked++;
        if (expected_q.size() == 0)
        begin
            report_mismatch("result with nothing expected, out_byte", out_byte, '0);
            return;
        end
        want = expected_q.pop_front();
        if (out_byte !== want.out_byte)
            report_mismatch("out_byte", out_byte, want.out_byte);
        if (last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 8'(last_of_run), 8'(want.last_of_run));
        if (text_done !== want.text_done)
            report_mismatch("text_done", 8'(text_done), 8'(want.text_done));
    endtask

    // Result side: check each popped transaction, stall in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_result();
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                rx_hold = $urandom_range(0, 12);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_q.size());
            $display("stream_substring_replace_tb: errors");
            $finish;
        end
    end

    // Send one input transaction; push stays high for a following one
    task automatic send_item(ssr_pkg::item_t it);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        push        <= 1'b1;
        text_byte   <= it.text_byte;
        has_byte    <= it.has_byte;
        end_of_text <= it.end_of_text;
        do
        begin
            @(posedge clk);
        end
        while (full);
        predict_rewrite(it);
        items_sent++;
    endtask

    task automatic send_byte(logic [ssr_pkg::BYTE_W-1:0] b, bit eot);
        send_item(ssr_pkg::item_t'{text_byte: b, has_byte: 1'b1, end_of_text: eot});
    endtask

    // A transaction with no valid byte: end-only or empty
    task automatic send_control(bit eot);
        send_item(ssr_pkg::item_t'{text_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0,
                                   end_of_text: eot});
    endtask

    task automatic send_text(string s, bit end_last);
        foreach (s[i])
            send_byte(s[i], end_last && i == s.len() - 1);
    endtask

    // Hold the input, drain every expected result, then let the engine settle
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; valid stays high for a following write
    task automatic cfg_write(logic [ssr_pkg::CFG_INDEX_W-1:0] index,
                             logic [ssr_pkg::WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (index)
            ssr_pkg::REG_PATTERN_BYTES:     pat_word    = data;
            ssr_pkg::REG_PATTERN_LENGTH:    pat_len_reg = data[ssr_pkg::LEN_W-1:0];
            ssr_pkg::REG_SUBSTITUTE_BYTES:  sub_word    = data;
            ssr_pkg::REG_SUBSTITUTE_LENGTH: sub_len_reg = data[ssr_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(logic [ssr_pkg::WORD_W-1:0] pattern,
                                logic [ssr_pkg::LEN_W-1:0] pattern_len,
                                logic [ssr_pkg::WORD_W-1:0] subst,
                                logic [ssr_pkg::LEN_W-1:0] subst_len);
        cfg_write(ssr_pkg::REG_PATTERN_BYTES, pattern);
        cfg_write(ssr_pkg::REG_PATTERN_LENGTH, 64'(pattern_len));
        cfg_write(ssr_pkg::REG_SUBSTITUTE_BYTES, subst);
        cfg_write(ssr_pkg::REG_SUBSTITUTE_LENGTH, 64'(subst_len));
        cfg_valid <= 1'b0;
        configs_written++;
    endtask

    function automatic logic [ssr_pkg::LEN_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return ssr_pkg::LEN_W'(MAX_PAT);
        if (roll == 2)
            return ssr_pkg::LEN_W'($urandom_range(9, 15));
        return ssr_pkg::LEN_W'($urandom_range(1, 4));
    endfunction

    // Reset configuration passes text through; includes an ignored empty transaction
    task automatic test_pass_through();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_control(1'b0);
        send_byte(8'h5A, 1'b1);
        wait_idle();
    endtask

    // Pattern "abc" -> "XYZW": rescan after a failed partial match, match on the
    // end transaction, and a flush of held bytes by an end-only transaction
    task automatic test_match_and_rescan();
        write_config(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_575A_5958, 4'd4);
        send_text("aabab", 1'b0);
        send_text("c", 1'b1);
        send_text("ab", 1'b0);
        send_control(1'b1);
        wait_idle();
    endtask

    // Change the pattern while bytes are held; an empty substitute deletes
    // matches, and an end that emits nothing gives no result at all
    task automatic test_reconfigure_mid_text();
        send_text("ab", 1'b0);
        wait_idle();
        write_config(64'h0000_0000_0000_6462, 4'd2, {$urandom, $urandom}, 4'd0);
        send_text("d", 1'b0);
        send_text("bd", 1'b1);
        wait_idle();
    endtask

    // Over-long lengths are taken as the maximum on both registers
    task automatic test_longest_lengths();
        write_config('1, 4'hF, 64'h0123_4567_89AB_CDEF, 4'hF);
        for (int i = 0; i < MAX_PAT; i++)
            send_byte(8'hFF, i == MAX_PAT - 1);
        wait_idle();
    endtask

    // Random configurations over a small alphabet; most text is whole or partial
    // copies of the pattern, some broken, with random bytes and ends mixed in
    task automatic test_random_texts();
        logic [ssr_pkg::BYTE_W-1:0] alphabet [3];
        logic [ssr_pkg::BYTE_W-1:0] b;
        logic [ssr_pkg::WORD_W-1:0] pattern;
        logic [ssr_pkg::LEN_W-1:0]  plen_code;
        int unsigned                plen;
        int unsigned                n;
        int unsigned                seg;
        int unsigned                cut;
        int unsigned                broken;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            gaps_on = (phase < RANDOM_PHASES - 2);
            foreach (alphabet[a])
                alphabet[a] = 8'($urandom_range(0, 255));
            plen_code = pick_length();
            plen      = clamp_len(plen_code, MAX_PAT);
            for (int i = 0; i < MAX_PAT; i++)
                pattern[i*8 +: 8] = (i < plen) ? alphabet[$urandom_range(0, 2)]
                                               : 8'($urandom_range(0, 255));
            write_config(pattern, plen_code, {$urandom, $urandom}, pick_length());
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                seg = $urandom_range(0, 11);
                if (seg <= 6)
                begin
                    // whole pattern or a prefix of it, one byte sometimes swapped
                    if (plen == 0)
                        cut = 3;
                    else if (seg <= 4 || plen < 2)
                        cut = plen;
                    else
                        cut = $urandom_range(1, plen - 1);
                    broken = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cut - 1) : cut;
                    for (int i = 0; i < cut; i++)
                    begin
                        b = (i == broken) ? alphabet[$urandom_range(0, 2)] : pattern[i*8 +: 8];
                        send_byte(b, i == cut - 1 && $urandom_range(0, 7) == 0);
                        n++;
                    end
                end
                else if (seg <= 8)
                begin
                    send_byte(alphabet[$urandom_range(0, 2)], $urandom_range(0, 9) == 0);
                    n++;
                end
                else if (seg == 9)
                begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                    n++;
                end
                else if (seg == 10)
                begin
                    send_control(1'b1);
                    n++;
                end
                else
                    send_control(1'b0);
            end
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_pass_through();
        test_match_and_rescan();
        test_reconfigure_mid_text();
        test_longest_lengths();
        test_random_texts();
        wait_idle();
        $display("Covered %0d input transactions under %0d configurations, %0d bytes checked",
                 items_sent, configs_written, bytes_checked);
        $display("Predicted %0d substitutions and %0d text ends, %0d mismatches",
                 matches_seen, texts_ended, error_count);
        if (error_count == 0)
            $display("stream_substring_replace_tb: clean");
        else
            $display("stream_substring_replace_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ssr_pkg.sv
rtl/core/ssr_fifo.sv
rtl/core/ssr_front.sv
rtl/core/ssr_engine.sv
rtl/core/stream_substring_replace.sv
sim/stream_substring_replace_tb.sv
